[sv/tcpt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package tcpt_pkg;

    localparam int NT = 3;
    localparam int AW = 2;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;
    localparam logic [1:0] CMD_GATE  = 2'd3;

    localparam logic [2:0] RS_CR13   = 3'd0;
    localparam logic [2:0] RS_CR2    = 3'd1;

    localparam logic [AW-1:0] TIMER3 = 2'd2;
    localparam logic [AW-1:0] TSEL_NONE = 2'd3;

    typedef struct packed {
        logic [1:0] cmd;
        logic [2:0] reg_sel;
        logic [7:0] write_data;
        logic [1:0] timer_sel;
        logic       gate_level;
    } ev_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq_out;
        logic       out_timer1;
        logic       out_timer2;
        logic       out_timer3;
    } res_t;

    typedef struct packed {
        logic [15:0] count;
        logic [7:0]  low;
    } cnt_rec_t;

    typedef struct packed {
        logic          en;
        logic [AW-1:0] addr;
        cnt_rec_t      data;
    } cnt_wr_t;

    // timer addressed by a beat
    function automatic logic [AW-1:0] ev_timer(input ev_t e);
        logic [AW-1:0] r;
        if (e.cmd == CMD_READ)
            r = e.reg_sel[2:1] - 2'd1;
        else
            r = e.timer_sel;
        return r;
    endfunction

endpackage
`default_nettype wire

[sv/tcpt_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module tcpt_ram #(
    parameter int W  = 24,
    parameter int D  = 3,
    parameter int AW = 2
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [W-1:0]  wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output logic      [W-1:0]  rdata
);

    logic [W-1:0] mem [D];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

[sv/tcpt_engine.sv]
`timescale 1ns / 1ps
`default_nettype none
module tcpt_engine (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             commit,
    input  wire tcpt_pkg::ev_t    ev,
    input  wire tcpt_pkg::cnt_rec_t rec,
    output tcpt_pkg::cnt_wr_t     wr,
    output tcpt_pkg::res_t        res
);
    import tcpt_pkg::*;

    logic [15:0] latch_reg [NT];
    logic [15:0] latch_next [NT];
    logic [15:0] rld_reg [NT];
    logic [15:0] rld_next [NT];
    logic [7:0]  ctrl_reg [NT];
    logic [7:0]  ctrl_next [NT];
    logic [NT-1:0] gate_reg, gate_next, wave_reg, wave_next, shot_reg, shot_next;
    logic [NT-1:0] irq_reg, irq_next, meas_reg, meas_next, tmo_reg, tmo_next;
    logic [NT-1:0] pend_reg, pend_next, vld_reg, vld_next;
    logic [2:0]  phase_reg, phase_next;
    logic [7:0]  msb_reg, msb_next, lsb_reg, lsb_next, stat_reg, stat_next;
    logic        spend_reg, spend_next;

    logic [AW-1:0] t;
    logic [15:0] cc;
    logic [7:0]  lc;
    logic [7:0]  rd;
    logic [7:0]  cw;
    logic        tv, go, tmo, was, now, meas, longer, any;
    logic [AW-1:0] tgt;
    logic [7:0]  s;

    always_comb
    begin
        latch_next = latch_reg;
        rld_next   = rld_reg;
        ctrl_next  = ctrl_reg;
        gate_next  = gate_reg;
        wave_next  = wave_reg;
        shot_next  = shot_reg;
        irq_next   = irq_reg;
        meas_next  = meas_reg;
        tmo_next   = tmo_reg;
        pend_next  = pend_reg;
        vld_next   = vld_reg;
        phase_next = phase_reg;
        msb_next   = msb_reg;
        lsb_next   = lsb_reg;
        stat_next  = stat_reg;
        spend_next = spend_reg;
        rd   = 8'h00;
        tmo  = 1'b0;
        go   = 1'b0;
        was  = 1'b0;
        now  = 1'b0;
        tgt  = '0;
        s    = 8'h00;
        wr   = '0;
        t    = ev_timer(ev);
        tv   = (t != TSEL_NONE);
        cw   = tv ? ctrl_reg[t] : 8'h00;
        meas = cw[3];
        longer = cw[5];
        // effective counter record: reload snapshot, memory, or reset value
        if (tv && pend_reg[t])
        begin
            cc = rld_reg[t];
            lc = rld_reg[t][7:0];
        end
        else if (tv && vld_reg[t])
        begin
            cc = rec.count;
            lc = rec.low;
        end
        else
        begin
            cc = 16'hFFFF;
            lc = 8'h00;
        end

        case (ev.cmd)
            CMD_WRITE:
            begin
                if (ev.reg_sel == RS_CR13)
                begin
                    tgt = ctrl_reg[1][0] ? 2'd0 : TIMER3;
                    was = ctrl_reg[0][0];
                    ctrl_next[tgt] = ev.write_data;
                    now = ctrl_next[0][0];
                    if (!was && now)
                        irq_next = '0;
                    if (was && !now)
                    begin
                        for (int i = 0; i < NT; i++)
                            rld_next[i] = latch_reg[i];
                        pend_next  = '1;
                        shot_next  = '0;
                        wave_next  = '0;
                        tmo_next   = '0;
                        phase_next = '0;
                    end
                end
                else if (ev.reg_sel == RS_CR2)
                    ctrl_next[1] = ev.write_data;
                else if (!ev.reg_sel[0])
                    msb_next = ev.write_data;
                else
                begin
                    tgt = ev.reg_sel[2:1] - 2'd1;
                    latch_next[tgt] = {msb_reg, ev.write_data};
                    if (!ctrl_reg[tgt][4])
                    begin
                        rld_next[tgt]  = {msb_reg, ev.write_data};
                        pend_next[tgt] = 1'b1;
                        shot_next[tgt] = 1'b0;
                        wave_next[tgt] = 1'b0;
                        tmo_next[tgt]  = 1'b0;
                        if (tgt == TIMER3)
                            phase_next = '0;
                    end
                    if (ctrl_reg[tgt][4:3] == 2'b00)
                        irq_next[tgt] = 1'b0;
                end
            end
            CMD_READ:
            begin
                if (ev.reg_sel == RS_CR2)
                begin
                    for (int i = 0; i < NT; i++)
                        s[i] = irq_reg[i];
                    any = 1'b0;
                    for (int i = 0; i < NT; i++)
                        any = any | (irq_reg[i] & ctrl_reg[i][6]);
                    s[7] = any;
                    stat_next  = s;
                    spend_next = 1'b1;
                    rd = s;
                end
                else if (ev.reg_sel != RS_CR13)
                begin
                    if (!ev.reg_sel[0])
                    begin
                        lsb_next = cc[7:0];
                        if (spend_reg && stat_reg[t])
                        begin
                            irq_next[t] = 1'b0;
                            spend_next  = 1'b0;
                        end
                        rd = cc[15:8];
                    end
                    else
                        rd = lsb_reg;
                end
            end
            CMD_TICK:
            begin
                if (tv)
                begin
                    go = !ctrl_reg[0][0] && !gate_reg[t]
                         && !(meas && (irq_reg[t] || !meas_reg[t]));
                    if (go && t == TIMER3 && ctrl_reg[2][0])
                    begin
                        phase_next = phase_reg + 3'd1;
                        go = (phase_next == 3'd0);
                    end
                    if (go)
                    begin
                        if (cw[2])
                        begin
                            if (lc != 8'h00)
                                lc = lc - 8'd1;
                            else if (cc[15:8] != 8'h00)
                            begin
                                cc = {cc[15:8] - 8'd1, latch_reg[t][7:0]};
                                lc = latch_reg[t][7:0];
                            end
                            else
                                tmo = 1'b1;
                        end
                        else if (cc != 16'h0000)
                            cc = cc - 16'd1;
                        else
                            tmo = 1'b1;
                        if (tmo)
                        begin
                            if (meas)
                            begin
                                tmo_next[t] = 1'b1;
                                if (longer)
                                    irq_next[t] = 1'b1;
                            end
                            else
                            begin
                                irq_next[t] = 1'b1;
                                if (longer)
                                begin
                                    wave_next[t] = 1'b0;
                                    shot_next[t] = 1'b1;
                                end
                            end
                            if (meas || !longer)
                                wave_next[t] = ~wave_reg[t];
                            cc = latch_reg[t];
                            lc = latch_reg[t][7:0];
                        end
                        wr.en   = commit;
                        wr.addr = t;
                        wr.data = '{count: cc, low: lc};
                        pend_next[t] = 1'b0;
                        vld_next[t]  = 1'b1;
                    end
                end
            end
            CMD_GATE:
            begin
                if (tv)
                begin
                    was = gate_reg[t];
                    gate_next[t] = ev.gate_level;
                    if (meas && !was && ev.gate_level)
                    begin
                        if (cw[4] && meas_reg[t])
                        begin
                            if (!tmo_reg[t] && !longer)
                                irq_next[t] = 1'b1;
                            meas_next[t] = 1'b0;
                        end
                    end
                    else if (was && !ev.gate_level)
                    begin
                        if (meas)
                        begin
                            if (!cw[4] && meas_reg[t])
                            begin
                                if (!tmo_reg[t] && !longer)
                                    irq_next[t] = 1'b1;
                                meas_next[t] = 1'b0;
                            end
                            if (!irq_next[t] && !meas_next[t])
                            begin
                                rld_next[t]  = latch_reg[t];
                                pend_next[t] = 1'b1;
                                shot_next[t] = 1'b0;
                                wave_next[t] = 1'b0;
                                tmo_next[t]  = 1'b0;
                                if (t == TIMER3)
                                    phase_next = '0;
                                meas_next[t] = 1'b1;
                            end
                        end
                        else
                        begin
                            rld_next[t]  = latch_reg[t];
                            pend_next[t] = 1'b1;
                            shot_next[t] = 1'b0;
                            wave_next[t] = 1'b0;
                            tmo_next[t]  = 1'b0;
                            if (t == TIMER3)
                                phase_next = '0;
                            irq_next[t] = 1'b0;
                        end
                    end
                end
            end
            default:
            begin
                rd = 8'h00;
            end
        endcase

        any = 1'b0;
        for (int i = 0; i < NT; i++)
            any = any | (irq_next[i] & ctrl_next[i][6]);
        res.read_data = rd;
        res.irq_out   = any;
        res.out_timer1 = ctrl_next[0][7] &
            ((!ctrl_next[0][3] && ctrl_next[0][5]) ? !shot_next[0] : wave_next[0]);
        res.out_timer2 = ctrl_next[1][7] &
            ((!ctrl_next[1][3] && ctrl_next[1][5]) ? !shot_next[1] : wave_next[1]);
        res.out_timer3 = ctrl_next[2][7] &
            ((!ctrl_next[2][3] && ctrl_next[2][5]) ? !shot_next[2] : wave_next[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NT; i++)
            begin
                latch_reg[i] <= 16'hFFFF;
                rld_reg[i]   <= 16'hFFFF;
                ctrl_reg[i]  <= 8'h00;
            end
            gate_reg  <= '0;
            wave_reg  <= '0;
            shot_reg  <= '0;
            irq_reg   <= '0;
            meas_reg  <= '0;
            tmo_reg   <= '0;
            pend_reg  <= '0;
            vld_reg   <= '0;
            phase_reg <= '0;
            msb_reg   <= '0;
            lsb_reg   <= '0;
            stat_reg  <= '0;
            spend_reg <= 1'b0;
        end
        else if (commit)
        begin
            latch_reg <= latch_next;
            rld_reg   <= rld_next;
            ctrl_reg  <= ctrl_next;
            gate_reg  <= gate_next;
            wave_reg  <= wave_next;
            shot_reg  <= shot_next;
            irq_reg   <= irq_next;
            meas_reg  <= meas_next;
            tmo_reg   <= tmo_next;
            pend_reg  <= pend_next;
            vld_reg   <= vld_next;
            phase_reg <= phase_next;
            msb_reg   <= msb_next;
            lsb_reg   <= lsb_next;
            stat_reg  <= stat_next;
            spend_reg <= spend_next;
        end
    end

endmodule
`default_nettype wire

[sv/three_channel_programmable_timer_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// Three-timer programmable timer.
// Input channel ev (ev_valid / ev_stall) carries one event per beat: a
// register write, a register read, a clock tick for one timer or a gate
// level change. Output channel res (res_valid / res_stall) returns one beat
// per event: read byte (zero unless a read), composite interrupt and the
// three output pins as they stand after the event.
// An accepted event is registered into the execute stage, and its result is
// registered onto res. The counter memory has a registered read, so an
// event reads its timer's counter on acceptance and executes from the
// execute stage, with the previous event's write-back forwarded.
// Throughput: one event per cycle while res is not stalled.
// Reset: all timers idle, control words clear (preset released, so timers
// count), latches and counters read as 0xFFFF. No clearing pass is needed.
// While res_stall holds back a waiting result the executing event is held
// and ev_stall is raised; nothing is lost or repeated.
module three_channel_programmable_timer_top (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           ev_valid,
    output logic                ev_stall,
    input  wire tcpt_pkg::ev_t  ev,
    output logic                res_valid,
    input  wire logic           res_stall,
    output tcpt_pkg::res_t      res
);
    import tcpt_pkg::*;

    logic          advance, accept, commit;
    logic          b_valid_reg, b_valid_next;
    ev_t           b_ev_reg;
    logic          fwd_hit_reg, fwd_hit_next;
    cnt_rec_t      fwd_data_reg;
    logic          res_valid_reg, res_valid_next;
    res_t          res_reg;
    logic [AW-1:0] raddr;
    logic [23:0]   ram_rdata;
    cnt_rec_t      rec;
    cnt_wr_t       wr;
    res_t          eng_res;

    assign advance  = !res_valid_reg || !res_stall;
    assign ev_stall = !advance;
    assign accept   = ev_valid && advance;
    assign commit   = advance && b_valid_reg;
    assign raddr    = ev_timer(ev);

    tcpt_ram #(.W(24), .D(NT), .AW(AW)) u_ram (
        .clk   (clk),
        .we    (wr.en),
        .waddr (wr.addr),
        .wdata (wr.data),
        .re    (accept && raddr != TSEL_NONE),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    // take the write-back of the event ahead when it hit the same timer
    assign rec = fwd_hit_reg ? fwd_data_reg : cnt_rec_t'(ram_rdata);

    tcpt_engine u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .commit (commit),
        .ev     (b_ev_reg),
        .rec    (rec),
        .wr     (wr),
        .res    (eng_res)
    );

    always_comb
    begin
        b_valid_next   = accept ? 1'b1 : (commit ? 1'b0 : b_valid_reg);
        fwd_hit_next   = accept ? (wr.en && wr.addr == raddr) : fwd_hit_reg;
        res_valid_next = commit ? 1'b1 : (res_stall ? res_valid_reg : 1'b0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg   <= 1'b0;
            fwd_hit_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg   <= b_valid_next;
            fwd_hit_reg   <= fwd_hit_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            b_ev_reg     <= ev;
            fwd_data_reg <= wr.data;
        end
        if (commit)
            res_reg <= eng_res;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> b_valid_reg)
        else $error("accepted event did not reach execute stage");

    a_write_needs_event: assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |-> (commit && b_ev_reg.cmd == CMD_TICK))
        else $error("counter write without an executing tick");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |-> (wr.addr != TSEL_NONE))
        else $error("counter write to an absent timer");

    a_commit_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> res_valid)
        else $error("executed event produced no result");

endmodule
`default_nettype wire
